// ===== hw/rtl/hodsi_pkg.sv =====
// ----------------------------------------------------------------------------
// hodsi_pkg
// Types and constants shared by the string-to-integer parser modules.
// ----------------------------------------------------------------------------
package hodsi_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned NUM_W     = 32;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned TDATA_IN_W  = 8;
    localparam int unsigned TDATA_OUT_W = 32;

    localparam logic [COUNT_W-1:0] HEX_MAX_DIGITS = 4'd8;
    localparam logic [COUNT_W-1:0] DEC_MAX_DIGITS = 4'd10;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
    localparam logic [CHAR_W-1:0] HEX_LETTER_BASE = 8'h0a;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_ZERO  = 3'd1,
        PH_DEC   = 3'd2,
        PH_HEX   = 3'd3,
        PH_DONE  = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [COUNT_W-1:0] digit_count;
        logic [NUM_W-1:0]   accumulator;
    } t_state;

    localparam t_state STATE_RESET = '{phase: PH_START, digit_count: '0, accumulator: '0};

endpackage

// ===== hw/rtl/hex_or_decimal_string_to_int.sv =====
// ----------------------------------------------------------------------------
// hex_or_decimal_string_to_int
// Parses a byte stream into an unsigned 32-bit number, hex after "0x" or
// "0X" and decimal otherwise.
//
// The slave channel takes one character per item in s_axis_tdata. Every
// character updates the parser state in the cycle it is accepted. A NUL
// character produces one item on the master channel carrying the parsed
// value, and returns the parser to its start state; other characters
// produce no item.
// The result appears on the master channel in the cycle after the NUL is
// accepted. The block accepts one character per cycle, limited only by the
// single output register: while that register holds a result the receiver
// has not taken, s_axis_tready is low unless m_axis_tready is high.
// Reset clears the parser state and empties the output register.
// ----------------------------------------------------------------------------
module hex_or_decimal_string_to_int (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Bits 7:0: ch.
    input  logic [hodsi_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Bits 31:0: number.
    output logic [hodsi_pkg::TDATA_OUT_W-1:0]     m_axis_tdata
);

    hodsi_pkg::t_state                      r_state;
    hodsi_pkg::t_state                      n_state;
    logic                                   emit;
    logic                                   in_fire;
    logic                                   r_out_valid;
    logic [hodsi_pkg::NUM_W-1:0]            r_out_data;

    hodsi_step u_step (
        .i_state (r_state),
        .i_ch    (s_axis_tdata[hodsi_pkg::CHAR_W-1:0]),
        .o_state (n_state),
        .o_emit  (emit)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hodsi_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_out_data <= r_state.accumulator;
        end
    end

endmodule

// ===== hw/rtl/hodsi_step.sv =====
// ----------------------------------------------------------------------------
// hodsi_step
// Next-state logic of the parser for one character, including the emit flag.
// ----------------------------------------------------------------------------
module hodsi_step (
    input  hodsi_pkg::t_state                  i_state,
    input  logic [hodsi_pkg::CHAR_W-1:0]       i_ch,
    output hodsi_pkg::t_state                  o_state,
    output logic                               o_emit
);

    logic                               is_dec;
    logic                               is_lc;
    logic                               is_uc;
    logic                               is_hex;
    logic                               is_x;
    logic [hodsi_pkg::CHAR_W-1:0]       dec_off;
    logic [hodsi_pkg::CHAR_W-1:0]       hex_off;
    logic [hodsi_pkg::DIGIT_W-1:0]      dec_val;
    logic [hodsi_pkg::DIGIT_W-1:0]      hex_val;
    logic [hodsi_pkg::COUNT_W-1:0]      base_cnt;
    logic [hodsi_pkg::NUM_W-1:0]        base_acc;
    logic [hodsi_pkg::NUM_W-1:0]        dec_acc;
    logic [hodsi_pkg::NUM_W-1:0]        hex_acc;
    hodsi_pkg::t_state                  dec_next;
    hodsi_pkg::t_state                  hex_next;

    always_comb begin
        is_dec = (i_ch >= hodsi_pkg::CH_ZERO) && (i_ch <= hodsi_pkg::CH_NINE);
        is_lc  = (i_ch >= hodsi_pkg::CH_LC_A) && (i_ch <= hodsi_pkg::CH_LC_F);
        is_uc  = (i_ch >= hodsi_pkg::CH_UC_A) && (i_ch <= hodsi_pkg::CH_UC_F);
        is_hex = is_dec || is_lc || is_uc;
        is_x   = (i_ch == hodsi_pkg::CH_LC_X) || (i_ch == hodsi_pkg::CH_UC_X);

        dec_off = i_ch - hodsi_pkg::CH_ZERO;
        dec_val = dec_off[hodsi_pkg::DIGIT_W-1:0];
        if (is_lc) begin
            hex_off = i_ch - hodsi_pkg::CH_LC_A + hodsi_pkg::HEX_LETTER_BASE;
        end else if (is_uc) begin
            hex_off = i_ch - hodsi_pkg::CH_UC_A + hodsi_pkg::HEX_LETTER_BASE;
        end else begin
            hex_off = dec_off;
        end
        hex_val = hex_off[hodsi_pkg::DIGIT_W-1:0];

        // A zero followed by a non-x byte starts decimal with that zero counted.
        if (i_state.phase == hodsi_pkg::PH_ZERO) begin
            base_cnt = hodsi_pkg::COUNT_W'(1);
            base_acc = '0;
        end else begin
            base_cnt = i_state.digit_count;
            base_acc = i_state.accumulator;
        end

        dec_acc = {base_acc[hodsi_pkg::NUM_W-4:0], 3'b000}
                + {base_acc[hodsi_pkg::NUM_W-2:0], 1'b0}
                + {{(hodsi_pkg::NUM_W-hodsi_pkg::DIGIT_W){1'b0}}, dec_val};
        hex_acc = {base_acc[hodsi_pkg::NUM_W-5:0], hex_val};

        if ((base_cnt >= hodsi_pkg::DEC_MAX_DIGITS) || !is_dec) begin
            dec_next = '{phase: hodsi_pkg::PH_DONE, digit_count: base_cnt,
                         accumulator: base_acc};
        end else begin
            dec_next = '{phase: hodsi_pkg::PH_DEC, digit_count: base_cnt + 1'b1,
                         accumulator: dec_acc};
        end

        if ((base_cnt >= hodsi_pkg::HEX_MAX_DIGITS) || !is_hex) begin
            hex_next = '{phase: hodsi_pkg::PH_DONE, digit_count: base_cnt,
                         accumulator: base_acc};
        end else begin
            hex_next = '{phase: hodsi_pkg::PH_HEX, digit_count: base_cnt + 1'b1,
                         accumulator: hex_acc};
        end

        o_emit = (i_ch == hodsi_pkg::CH_NUL);

        if (o_emit) begin
            o_state = hodsi_pkg::STATE_RESET;
        end else begin
            unique case (i_state.phase)
                hodsi_pkg::PH_START: begin
                    if (i_ch == hodsi_pkg::CH_ZERO) begin
                        o_state       = i_state;
                        o_state.phase = hodsi_pkg::PH_ZERO;
                    end else begin
                        o_state = dec_next;
                    end
                end
                hodsi_pkg::PH_ZERO: begin
                    if (is_x) begin
                        o_state = '{phase: hodsi_pkg::PH_HEX, digit_count: '0,
                                    accumulator: '0};
                    end else begin
                        o_state = dec_next;
                    end
                end
                hodsi_pkg::PH_DEC: begin
                    o_state = dec_next;
                end
                hodsi_pkg::PH_HEX: begin
                    o_state = hex_next;
                end
                default: begin
                    o_state       = i_state;
                    o_state.phase = hodsi_pkg::PH_DONE;
                end
            endcase
        end
    end

endmodule
